### src/quaternion_to_euler_angles_top_macros.svh
// Assertion helpers used by the verification checker of this block.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define Q2E_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("q2e assertion failed");

// Next-cycle implication, disabled during reset.
`define Q2E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("q2e assertion failed");

`endif

### src/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

   // Quaternion product terms, at most 2^32 in magnitude.
   localparam int TERM_W   = 36;
   // CORDIC datapath, leaves room for the gain of about 1.65.
   localparam int CORDIC_W = 38;
   // Angle accumulator in 32-bit binary units plus guard bits.
   localparam int Z_W      = 34;
   // Rounded angle before the final 16-bit wrap or clamp.
   localparam int ANGLE_W  = Z_W - 16;
   // Clamped pitch term, within plus or minus 2^28.
   localparam int CLAMP_W  = 30;
   // Square root radicand and working registers.
   localparam int RAD_W    = 58;
   // One square root step per result bit of a 29-bit root.
   localparam int ISQ_STEPS = 29;
   localparam int TABLE_LEN = 24;

   localparam logic signed [TERM_W-1:0]  ONE_Q28    = TERM_W'(64'sd268435456);
   localparam logic signed [CLAMP_W-1:0] ONE_Q28_C  = CLAMP_W'(64'sd268435456);
   localparam logic signed [Z_W-1:0]     HALF_PI_Z  = Z_W'(64'sd1073741824);
   localparam logic [RAD_W-1:0]          ONE_Q56    = RAD_W'(1) << 56;
   localparam logic signed [Z_W-1:0]     ROUND_HALF = Z_W'(64'sd32768);
   localparam logic signed [ANGLE_W-1:0] PITCH_MAX  = ANGLE_W'(64'sd16384);
   localparam logic signed [ANGLE_W-1:0] PITCH_MIN  = -ANGLE_W'(64'sd16384);

   // atan(2^-i) with 2^31 standing for pi.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

### src/quaternion_to_euler_angles_top.sv
`default_nettype none
// Quaternion to 3-2-1 Euler angle converter.
// A transaction on the request side is one unit quaternion (w, x, y, z) in
// signed Q1.14 on req_quat_*; it is taken at a rising edge where start is
// high and busy is low. Busy is never raised, so a new quaternion may be
// offered in every cycle and the block sustains one transaction per clock.
// Each request yields exactly one response transaction: rsp_valid is high for
// one cycle with yaw, pitch and roll as signed binary angles (32768 = pi).
// The response path runs through the input, product, term and radicand
// registers, the square root unit with one pipeline stage per root bit
// (29 stages), the CORDIC pre-rotation register, one stage per CORDIC
// iteration, and the rounding and output registers.
// Roll and yaw are four-quadrant arctangents; pitch is the arcsine of the
// clamped term 2(wy - zx), taken as atan2 of the term and its cosine.
// The receiver cannot stall, so results are simply presented for one cycle.
// A synchronous reset empties the pipeline by clearing its valid bits; items
// in flight at reset are dropped and no response is produced for them.
module quaternion_to_euler_angles_top
   import q2e_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        start,
   output logic              busy,
   input  wire  logic signed [15:0] req_quat_w,
   input  wire  logic signed [15:0] req_quat_x,
   input  wire  logic signed [15:0] req_quat_y,
   input  wire  logic signed [15:0] req_quat_z,
   output logic              rsp_valid,
   output logic signed [15:0] rsp_yaw_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle
);

   // Terms that ride along the square root pipeline untouched.
   typedef struct packed {
      logic signed [TERM_W-1:0]  roll_y;
      logic signed [TERM_W-1:0]  roll_x;
      logic signed [TERM_W-1:0]  yaw_y;
      logic signed [TERM_W-1:0]  yaw_x;
      logic signed [CLAMP_W-1:0] pitch_s;
   } terms_type;

   // Stage 1: input capture.
   logic               in_vld_ff;
   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      w_ff <= req_quat_w;
      x_ff <= req_quat_x;
      y_ff <= req_quat_y;
      z_ff <= req_quat_z;
   end

   // Stage 2: the nine products, each a 16 by 16 multiply.
   logic               prod_vld_ff;
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= in_vld_ff;
      end
      wx_ff <= w_ff * x_ff;
      yz_ff <= y_ff * z_ff;
      xx_ff <= x_ff * x_ff;
      yy_ff <= y_ff * y_ff;
      wy_ff <= w_ff * y_ff;
      zx_ff <= z_ff * x_ff;
      wz_ff <= w_ff * z_ff;
      xy_ff <= x_ff * y_ff;
      zz_ff <= z_ff * z_ff;
   end

   // Stage 3: the arctangent operands and the clamped pitch term, in Q28.
   logic                     term_vld_ff;
   terms_type                terms_in, terms_ff;
   logic signed [TERM_W-1:0] pitch_raw;

   always_comb begin
      terms_in.roll_y = (TERM_W'(wx_ff) + TERM_W'(yz_ff)) <<< 1;
      terms_in.roll_x = ONE_Q28 - ((TERM_W'(xx_ff) + TERM_W'(yy_ff)) <<< 1);
      terms_in.yaw_y  = (TERM_W'(wz_ff) + TERM_W'(xy_ff)) <<< 1;
      terms_in.yaw_x  = ONE_Q28 - ((TERM_W'(yy_ff) + TERM_W'(zz_ff)) <<< 1);
      pitch_raw       = (TERM_W'(wy_ff) - TERM_W'(zx_ff)) <<< 1;
      if (pitch_raw > ONE_Q28) begin
         terms_in.pitch_s = ONE_Q28_C;
      end else if (pitch_raw < -ONE_Q28) begin
         terms_in.pitch_s = -ONE_Q28_C;
      end else begin
         terms_in.pitch_s = pitch_raw[CLAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_vld_ff <= 1'b0;
      end else begin
         term_vld_ff <= prod_vld_ff;
      end
      terms_ff <= terms_in;
   end

   // Stage 4 and the square root pipeline. Entry 0 holds the radicand
   // 1 - s^2 in Q56; each later entry resolves one bit of the root.
   logic                           isq_vld_ff [ISQ_STEPS+1];
   logic [RAD_W-1:0]               isq_v_ff   [ISQ_STEPS+1];
   logic [RAD_W-1:0]               isq_r_ff   [ISQ_STEPS+1];
   terms_type                      isq_t_ff   [ISQ_STEPS+1];
   logic signed [2*CLAMP_W-1:0]    pitch_sq;

   assign pitch_sq = terms_ff.pitch_s * terms_ff.pitch_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         isq_vld_ff[0] <= 1'b0;
      end else begin
         isq_vld_ff[0] <= term_vld_ff;
      end
      isq_v_ff[0] <= ONE_Q56 - RAD_W'(pitch_sq);
      isq_r_ff[0] <= '0;
      isq_t_ff[0] <= terms_ff;
   end

   for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
      localparam logic [RAD_W-1:0] BIT_J = RAD_W'(1) << (2 * (ISQ_STEPS - 1 - j));
      logic [RAD_W-1:0] trial;
      logic [RAD_W-1:0] v_in, r_in;

      always_comb begin
         trial = isq_r_ff[j] + BIT_J;
         if (isq_v_ff[j] >= trial) begin
            v_in = isq_v_ff[j] - trial;
            r_in = (isq_r_ff[j] >> 1) + BIT_J;
         end else begin
            v_in = isq_v_ff[j];
            r_in = isq_r_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            isq_vld_ff[j+1] <= 1'b0;
         end else begin
            isq_vld_ff[j+1] <= isq_vld_ff[j];
         end
         isq_v_ff[j+1] <= v_in;
         isq_r_ff[j+1] <= r_in;
         isq_t_ff[j+1] <= isq_t_ff[j];
      end
   end

   // Three CORDIC pipelines run side by side on the aligned operands.
   terms_type                  cd_terms;
   logic signed [CORDIC_W-1:0] pitch_cos;
   logic                       roll_vld, pitch_vld, yaw_vld;
   logic signed [ANGLE_W-1:0]  roll_ang, pitch_ang, yaw_ang;

   assign cd_terms  = isq_t_ff[ISQ_STEPS];
   assign pitch_cos = $signed(CORDIC_W'(isq_r_ff[ISQ_STEPS]));

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (isq_vld_ff[ISQ_STEPS]),
      .in_y      (CORDIC_W'(cd_terms.roll_y)),
      .in_x      (CORDIC_W'(cd_terms.roll_x)),
      .out_valid (roll_vld),
      .out_angle (roll_ang)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (isq_vld_ff[ISQ_STEPS]),
      .in_y      (CORDIC_W'(cd_terms.pitch_s)),
      .in_x      (pitch_cos),
      .out_valid (pitch_vld),
      .out_angle (pitch_ang)
   );

   q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (isq_vld_ff[ISQ_STEPS]),
      .in_y      (CORDIC_W'(cd_terms.yaw_y)),
      .in_x      (CORDIC_W'(cd_terms.yaw_x)),
      .out_valid (yaw_vld),
      .out_angle (yaw_ang)
   );

   // Output register: wrap roll and yaw to 16 bits, clamp pitch to a
   // quarter turn either way.
   logic                      out_vld_ff;
   logic signed [15:0]        yaw_ff, pitch_ff, roll_ff;
   logic signed [ANGLE_W-1:0] pitch_lim;

   always_comb begin
      if (pitch_ang > PITCH_MAX) begin
         pitch_lim = PITCH_MAX;
      end else if (pitch_ang < PITCH_MIN) begin
         pitch_lim = PITCH_MIN;
      end else begin
         pitch_lim = pitch_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= roll_vld && pitch_vld && yaw_vld;
      end
      yaw_ff   <= yaw_ang[15:0];
      pitch_ff <= pitch_lim[15:0];
      roll_ff  <= roll_ang[15:0];
   end

   assign busy            = 1'b0;
   assign rsp_valid       = out_vld_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;

endmodule
`default_nettype wire

### src/q2e_cordic.sv
`default_nettype none
module q2e_cordic
   import q2e_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  wire  logic                       clock,
   input  wire  logic                       reset,
   input  wire  logic                       in_valid,
   input  wire  logic signed [CORDIC_W-1:0] in_y,
   input  wire  logic signed [CORDIC_W-1:0] in_x,
   output logic                             out_valid,
   output logic signed [ANGLE_W-1:0]        out_angle
);

   logic signed [CORDIC_W-1:0] x_ff [STEPS+1];
   logic signed [CORDIC_W-1:0] y_ff [STEPS+1];
   logic signed [Z_W-1:0]      z_ff [STEPS+1];
   logic                       vld_ff  [STEPS+1];
   logic                       zero_ff [STEPS+1];

   logic signed [CORDIC_W-1:0] x0_in, y0_in;
   logic signed [Z_W-1:0]      z0_in;
   logic signed [Z_W-1:0]      rnd_sum;
   logic signed [ANGLE_W-1:0]  angle_ff;
   logic                       angle_vld_ff;

   // Rotate left-half vectors by a quarter turn so the iterations converge.
   always_comb begin
      x0_in = in_x;
      y0_in = in_y;
      z0_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x0_in = in_y;
            y0_in = -in_x;
            z0_in = HALF_PI_Z;
         end else begin
            x0_in = -in_y;
            y0_in = in_x;
            z0_in = -HALF_PI_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0]    <= x0_in;
      y_ff[0]    <= y0_in;
      z_ff[0]    <= z0_in;
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [Z_W-1:0] ATAN_I = $signed(Z_W'(atan_entry(5'(i))));
      logic signed [CORDIC_W-1:0] x_in, y_in;
      logic signed [Z_W-1:0]      z_in;

      always_comb begin
         if (y_ff[i] >= 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ATAN_I;
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ATAN_I;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   // Round half up from 32-bit to 16-bit binary units.
   assign rnd_sum = z_ff[STEPS] + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_vld_ff <= 1'b0;
      end else begin
         angle_vld_ff <= vld_ff[STEPS];
      end
      angle_ff <= zero_ff[STEPS] ? '0 : rnd_sum[Z_W-1:16];
   end

   assign out_valid = angle_vld_ff;
   assign out_angle = angle_ff;

endmodule
`default_nettype wire

### src/q2e_checker.sv
`default_nettype none
`include "quaternion_to_euler_angles_top_macros.svh"
module q2e_checker #(
   parameter int CORDIC_STEPS = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [15:0] req_quat_w,
   input wire logic [15:0] req_quat_x,
   input wire logic [15:0] req_quat_y,
   input wire logic [15:0] req_quat_z,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_yaw_angle,
   input wire logic [15:0] rsp_pitch_angle,
   input wire logic [15:0] rsp_roll_angle
);

   localparam int LATENCY = 36 + CORDIC_STEPS;

   logic identity_req;
   logic pitch_ok;
   logic angles_zero;

   assign identity_req = start && !busy && (req_quat_w == 16'h4000) &&
                         (req_quat_x == 16'h0000) && (req_quat_y == 16'h0000) &&
                         (req_quat_z == 16'h0000);
   assign pitch_ok = ($signed(rsp_pitch_angle) <= 16'sd16384) &&
                     ($signed(rsp_pitch_angle) >= -16'sd16384);
   assign angles_zero = (rsp_yaw_angle == 16'h0) && (rsp_pitch_angle == 16'h0) &&
                        (rsp_roll_angle == 16'h0);

   // A response only ever follows a request by the fixed latency.
   `Q2E_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY))
   // Pitch never leaves a quarter turn either way.
   `Q2E_ASSERT_IMPLY(a_pitch_range, clock, reset, rsp_valid, pitch_ok)
   // The identity rotation gives all angles zero.
   `Q2E_ASSERT_IMPLY(a_identity, clock, reset, rsp_valid && $past(identity_req, LATENCY), angles_zero)
   // The block never refuses a request.
   `Q2E_ASSERT_NEXT(a_never_busy, clock, reset, 1'b1, !busy)

endmodule

bind quaternion_to_euler_angles_top q2e_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_q2e_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_quat_w      (req_quat_w),
   .req_quat_x      (req_quat_x),
   .req_quat_y      (req_quat_y),
   .req_quat_z      (req_quat_z),
   .rsp_valid       (rsp_valid),
   .rsp_yaw_angle   (rsp_yaw_angle),
   .rsp_pitch_angle (rsp_pitch_angle),
   .rsp_roll_angle  (rsp_roll_angle)
);
`default_nettype wire
